@@ rtl/pqs_pkg.sv @@
// package for the process queue set: word types, command, status and queue codes
// no dependencies
package pqs_pkg;

    localparam int QueueDepthDefault = 16;
    localparam int IdBitsDefault = 16;
    localparam int CountW = 5;

    localparam logic [2:0] CMD_ENQ = 3'd0;
    localparam logic [2:0] CMD_POP = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_IO_START = 3'd3;
    localparam logic [2:0] CMD_IO_FINISH = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_BADKIND = 3'd4;

    localparam logic [1:0] Q_HIGH = 2'd0;
    localparam logic [1:0] Q_LOW = 2'd1;
    localparam logic [1:0] Q_IO = 2'd2;
    localparam logic [1:0] Q_NONE = 2'd3;

    localparam logic [1:0] KIND_DISK = 2'd0;
    localparam logic [1:0] KIND_BAD = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  queue_sel;
        logic [15:0] process_id;
        logic [1:0]  io_kind;
        logic [31:0] now_time;
        logic [31:0] io_duration;
    } pqs_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] process_id_res;
        logic [31:0] return_time;
        logic [1:0]  dest_queue;
        logic [4:0]  count_high;
        logic [4:0]  count_low;
        logic [4:0]  count_io;
    } pqs_out_t;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture input word
        logic       scan;      // step index past a non-matching entry
        logic       take;      // capture current entry, hold index
        logic       shift;     // move entry idx+1 to idx in source queue
        logic       drop;      // decrement source count
        logic       push;      // append captured id to destination
        logic [1:0] src;
        logic [1:0] dst;
    } pqs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;         // current entry matches captured id
        logic idx_end;     // index has reached count of source
        logic shift_end;   // idx+1 reaches count of source
        logic src_empty;
        logic dst_full;
    } pqs_stat_t;

endpackage

@@ rtl/process_queue_set_with_io_routing_top.sv @@
// one word at a time; the next word is taken the cycle after the result is registered,
// and the serial walk over one read port of the source queue sets the pace
// reset: asynchronous active low, clears counts and control; queue entries are left as is
// top level: handshake ports, controller and datapath
module process_queue_set_with_io_routing_top
    import pqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    parameter int ID_BITS = IdBitsDefault
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  pqs_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output pqs_out_t out_data
);
    pqs_cmd_t cmd;
    pqs_stat_t stat;
    logic [ID_BITS-1:0] id_q;
    logic [CountW-1:0] cnt_h, cnt_l, cnt_i;

    pqs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(in_data), .cmd(cmd), .stat(stat),
        .id_q(id_q), .cnt_h(cnt_h), .cnt_l(cnt_l), .cnt_i(cnt_i)
    );

    pqs_ctrl #(.ID_BITS(ID_BITS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_word(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_word(out_data), .cmd(cmd), .stat(stat), .id_q(id_q),
        .cnt_h(cnt_h), .cnt_l(cnt_l), .cnt_i(cnt_i)
    );
endmodule

@@ rtl/pqs_datapath.sv @@
// datapath: three id queues, counts, scan index and captured id
// depends on pqs_pkg
module pqs_datapath
    import pqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    parameter int ID_BITS = IdBitsDefault
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  pqs_in_t      in_word,
    input  pqs_cmd_t     cmd,
    output pqs_stat_t    stat,
    output logic [ID_BITS-1:0] id_q,
    output logic [CountW-1:0]  cnt_h,
    output logic [CountW-1:0]  cnt_l,
    output logic [CountW-1:0]  cnt_i
);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [ID_BITS-1:0] mem_h [QUEUE_DEPTH];
    logic [ID_BITS-1:0] mem_l [QUEUE_DEPTH];
    logic [ID_BITS-1:0] mem_i [QUEUE_DEPTH];
    logic [CW-1:0] cnt_reg [3];
    logic [CW-1:0] idx_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] rd_data;
    logic [CW-1:0] src_cnt, dst_cnt, idx_p1;
    logic [IW-1:0] rd_addr;

    assign src_cnt = (cmd.src == Q_NONE) ? '0 : cnt_reg[cmd.src];
    assign dst_cnt = (cmd.dst == Q_NONE) ? CW'(QUEUE_DEPTH) : cnt_reg[cmd.dst];
    assign idx_p1 = idx_reg + 1'b1;
    assign rd_addr = cmd.shift ? idx_p1[IW-1:0] : idx_reg[IW-1:0];

    always_comb
    begin
        case (cmd.src)
            Q_HIGH:  rd_data = mem_h[rd_addr];
            Q_LOW:   rd_data = mem_l[rd_addr];
            default: rd_data = mem_i[rd_addr];
        endcase
    end

    assign stat.hit = (rd_data == id_reg);
    assign stat.idx_end = (idx_reg >= src_cnt);
    assign stat.shift_end = (idx_p1 >= src_cnt);
    assign stat.src_empty = (src_cnt == '0);
    assign stat.dst_full = (dst_cnt >= CW'(QUEUE_DEPTH));

    // memories: shift write and push write are never in the same cycle
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            case (cmd.src)
                Q_HIGH:  mem_h[idx_reg[IW-1:0]] <= rd_data;
                Q_LOW:   mem_l[idx_reg[IW-1:0]] <= rd_data;
                default: mem_i[idx_reg[IW-1:0]] <= rd_data;
            endcase
        end
        else if (cmd.push)
        begin
            case (cmd.dst)
                Q_HIGH:  mem_h[dst_cnt[IW-1:0]] <= id_reg;
                Q_LOW:   mem_l[dst_cnt[IW-1:0]] <= id_reg;
                default: mem_i[dst_cnt[IW-1:0]] <= id_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            cnt_reg[2] <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.shift || cmd.scan)
                idx_reg <= idx_p1;
            if (cmd.drop && cmd.src != Q_NONE)
                cnt_reg[cmd.src] <= cnt_reg[cmd.src] - 1'b1;
            if (cmd.push && cmd.dst != Q_NONE)
                cnt_reg[cmd.dst] <= cnt_reg[cmd.dst] + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            id_reg <= ID_BITS'(in_word.process_id);
        else if (cmd.take)
            id_reg <= rd_data;
    end

    assign id_q = id_reg;
    assign cnt_h = CountW'(cnt_reg[0]);
    assign cnt_l = CountW'(cnt_reg[1]);
    assign cnt_i = CountW'(cnt_reg[2]);

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CW'(QUEUE_DEPTH) && cnt_reg[1] <= CW'(QUEUE_DEPTH)
        && cnt_reg[2] <= CW'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.dst_full)
        else $error("push into full queue");
    a_no_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop |-> !stat.src_empty)
        else $error("drop from empty queue");
`endif
endmodule

@@ rtl/pqs_ctrl.sv @@
// controller: handshake, command decode and scan/compact sequencing
// depends on pqs_pkg
module pqs_ctrl
    import pqs_pkg::*;
#(
    parameter int ID_BITS = IdBitsDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  pqs_in_t   in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output pqs_out_t  out_word,
    output pqs_cmd_t  cmd,
    input  pqs_stat_t stat,
    input  logic [ID_BITS-1:0] id_q,
    input  logic [CountW-1:0]  cnt_h,
    input  logic [CountW-1:0]  cnt_l,
    input  logic [CountW-1:0]  cnt_i
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    pqs_in_t req_reg;
    logic [2:0] st_reg, st_next;
    logic [1:0] dest_reg, dest_next;
    logic ok_reg, ok_next;
    logic out_valid_reg;
    pqs_out_t out_reg;
    logic [1:0] src, dst;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        src = req_reg.queue_sel;
        dst = Q_NONE;
        case (req_reg.command)
            CMD_ENQ:       begin src = Q_NONE; dst = req_reg.queue_sel; end
            CMD_IO_START:  begin src = Q_NONE; dst = Q_IO; end
            CMD_IO_FINISH: begin
                src = Q_IO;
                dst = (req_reg.io_kind == KIND_DISK) ? Q_LOW : Q_HIGH;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        st_next = st_reg;
        dest_next = dest_reg;
        ok_next = ok_reg;
        cmd = '0;
        cmd.src = src;
        cmd.dst = dst;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                st_next = ST_OK;
                dest_next = Q_NONE;
                ok_next = 1'b0;
                state_next = S_DONE;
                case (req_reg.command)
                    CMD_ENQ, CMD_IO_START:
                        if (stat.dst_full)
                            st_next = ST_FULL;
                        else
                            state_next = S_PUSH;
                    CMD_POP:
                        if (stat.src_empty)
                            st_next = ST_EMPTY;
                        else
                            state_next = S_SCAN;
                    CMD_REMOVE:
                        if (stat.src_empty)
                            st_next = ST_EMPTY;
                        else
                            state_next = S_SCAN;
                    CMD_IO_FINISH:
                        if (req_reg.io_kind == KIND_BAD)
                            st_next = ST_BADKIND;
                        else
                            state_next = S_SCAN;
                    default: ;
                endcase
            end
            S_SCAN:
            begin
                // pop matches the head entry unconditionally
                if (stat.idx_end)
                begin
                    st_next = ST_NOTFOUND;
                    state_next = S_DONE;
                end
                else if (stat.hit || req_reg.command == CMD_POP)
                begin
                    cmd.take = 1'b1;
                    if (req_reg.command == CMD_IO_FINISH && stat.dst_full)
                    begin
                        st_next = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_SHIFT;
                end
                else
                    cmd.scan = 1'b1;
            end
            S_SHIFT:
            begin
                if (stat.shift_end)
                begin
                    cmd.drop = 1'b1;
                    ok_next = 1'b1;
                    if (req_reg.command == CMD_IO_FINISH)
                        state_next = S_PUSH;
                    else
                        state_next = S_DONE;
                end
                else
                    cmd.shift = 1'b1;
            end
            S_PUSH:
            begin
                cmd.push = 1'b1;
                ok_next = 1'b1;
                dest_next = dst;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        dest_reg <= dest_next;
        ok_reg <= ok_next;
        if (cmd.load)
            req_reg <= in_word;
        if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
        begin
            out_reg.status <= st_reg;
            out_reg.process_id_res <= ok_reg ? 16'(id_q) : '0;
            out_reg.return_time <= (ok_reg && req_reg.command == CMD_IO_START)
                ? req_reg.now_time + req_reg.io_duration : '0;
            out_reg.dest_queue <= dest_reg;
            out_reg.count_high <= cnt_h;
            out_reg.count_low <= cnt_l;
            out_reg.count_io <= cnt_i;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word = out_reg;

`ifndef SYNTHESIS
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("result not presented");
    a_shift_mutex: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.shift && cmd.push))
        else $error("shift and push together");
`endif
endmodule

@@ dv/tb_process_queue_set_with_io_routing_top.sv @@
// self-checking testbench for the process queue set with i/o routing
// depends on pqs_pkg and process_queue_set_with_io_routing_top; predicts every result word
`timescale 1ns / 1ps
module tb_process_queue_set_with_io_routing_top
    import pqs_pkg::*;
;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] KIND_TAPE_C = 2'd1;
    localparam logic [1:0] KIND_PRN_C = 2'd2;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    pqs_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    pqs_out_t out_data;

    process_queue_set_with_io_routing_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    // predictor state
    logic [15:0] shadow_q[3][$];
    pqs_out_t    pending_results[$];

    int mismatches;
    int words_sent;
    int words_checked;
    int idle_pct;
    int stall_pct;
    bit hold_receiver;
    int quiet_cycles;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int find_id(int q, logic [15:0] id);
        for (int i = 0; i < shadow_q[q].size(); i++)
            if (shadow_q[q][i] == id)
                return i;
        return -1;
    endfunction

    function automatic pqs_out_t predict_queue_step(pqs_in_t w);
        pqs_out_t r;
        int pos;
        int tgt;
        r = '0;
        r.status = ST_OK;
        r.dest_queue = Q_NONE;
        case (w.command)
            CMD_ENQ:
                if (w.queue_sel != Q_NONE && shadow_q[w.queue_sel].size() < DEPTH)
                begin
                    shadow_q[w.queue_sel].push_back(w.process_id);
                    r.process_id_res = w.process_id;
                    r.dest_queue = w.queue_sel;
                end
                else
                    r.status = ST_FULL;
            CMD_POP:
                if (w.queue_sel == Q_NONE || shadow_q[w.queue_sel].size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.process_id_res = shadow_q[w.queue_sel].pop_front();
            CMD_REMOVE:
                if (w.queue_sel == Q_NONE || shadow_q[w.queue_sel].size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    pos = find_id(w.queue_sel, w.process_id);
                    if (pos < 0)
                        r.status = ST_NOTFOUND;
                    else
                    begin
                        r.process_id_res = shadow_q[w.queue_sel][pos];
                        shadow_q[w.queue_sel].delete(pos);
                    end
                end
            CMD_IO_START:
                if (shadow_q[Q_IO].size() < DEPTH)
                begin
                    shadow_q[Q_IO].push_back(w.process_id);
                    r.process_id_res = w.process_id;
                    r.return_time = w.now_time + w.io_duration;
                    r.dest_queue = Q_IO;
                end
                else
                    r.status = ST_FULL;
            CMD_IO_FINISH:
                if (w.io_kind == KIND_BAD)
                    r.status = ST_BADKIND;
                else
                begin
                    tgt = (w.io_kind == KIND_DISK) ? Q_LOW : Q_HIGH;
                    pos = find_id(Q_IO, w.process_id);
                    if (pos < 0)
                        r.status = ST_NOTFOUND;
                    else if (shadow_q[tgt].size() >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        r.process_id_res = shadow_q[Q_IO][pos];
                        shadow_q[Q_IO].delete(pos);
                        shadow_q[tgt].push_back(r.process_id_res);
                        r.dest_queue = logic'(tgt) ? Q_LOW : Q_HIGH;
                    end
                end
            default: ;
        endcase
        r.count_high = 5'(shadow_q[Q_HIGH].size());
        r.count_low = 5'(shadow_q[Q_LOW].size());
        r.count_io = 5'(shadow_q[Q_IO].size());
        return r;
    endfunction

    // one word per call, prediction made on acceptance; valid stays up between
    // back to back words and drops while idling or draining
    task automatic send_word(pqs_in_t w);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_queue_step(w));
        words_sent++;
    endtask

    function automatic pqs_in_t make_word(logic [2:0] cmd, logic [1:0] sel, logic [15:0] id,
                                          logic [1:0] kind, logic [31:0] now_t,
                                          logic [31:0] dur);
        pqs_in_t w;
        w.command = cmd;
        w.queue_sel = sel;
        w.process_id = id;
        w.io_kind = kind;
        w.now_time = now_t;
        w.io_duration = dur;
        return w;
    endfunction

    // id drawn mostly from those already queued so removals and finishes hit
    function automatic logic [15:0] pick_id(int q);
        if (shadow_q[q].size() > 0 && $urandom_range(99) < 75)
            return shadow_q[q][$urandom_range(shadow_q[q].size() - 1)];
        return $urandom_range(15) == 0 ? 16'hffff : 16'($urandom_range(40));
    endfunction

    function automatic pqs_in_t random_word();
        logic [2:0] cmd;
        logic [1:0] sel;
        cmd = 3'($urandom_range(99) < 4 ? $urandom_range(7, 5) : $urandom_range(4));
        sel = 2'($urandom_range(99) < 6 ? 3 : $urandom_range(2));
        return make_word(cmd, sel,
                         cmd == CMD_IO_FINISH ? pick_id(Q_IO) :
                         (sel == Q_NONE ? 16'($urandom) : pick_id(sel)),
                         2'($urandom_range(3)), $urandom, $urandom);
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        // empty queues, bad select, absent ids
        send_word(make_word(CMD_POP, Q_HIGH, 16'h0, KIND_DISK, 0, 0));
        send_word(make_word(CMD_REMOVE, Q_IO, 16'h1, KIND_DISK, 0, 0));
        send_word(make_word(CMD_POP, Q_NONE, 16'h1, KIND_DISK, 0, 0));
        send_word(make_word(CMD_REMOVE, Q_NONE, 16'h1, KIND_DISK, 0, 0));
        send_word(make_word(CMD_ENQ, Q_NONE, 16'h5, KIND_DISK, 0, 0));
        send_word(make_word(CMD_IO_FINISH, Q_HIGH, 16'h7, KIND_TAPE_C, 0, 0));
        // extremes and wrap of return time
        send_word(make_word(CMD_ENQ, Q_HIGH, 16'hffff, KIND_DISK, 0, 0));
        send_word(make_word(CMD_ENQ, Q_LOW, 16'h0000, KIND_DISK, 0, 0));
        send_word(make_word(CMD_IO_START, Q_HIGH, 16'haaaa, KIND_DISK, '1, '1));
        send_word(make_word(CMD_IO_START, Q_LOW, 16'h5555, KIND_DISK, 32'h8000_0000, 1));
        send_word(make_word(CMD_IO_START, Q_IO, 16'h0003, KIND_DISK, 32'h5555_aaaa,
                            32'haaaa_5555));
        send_word(make_word(CMD_IO_FINISH, Q_HIGH, 16'haaaa, KIND_BAD, 0, 0));
        send_word(make_word(CMD_IO_FINISH, Q_HIGH, 16'h5555, KIND_DISK, 0, 0));
        send_word(make_word(CMD_IO_FINISH, Q_HIGH, 16'haaaa, KIND_TAPE_C, 0, 0));
        send_word(make_word(CMD_IO_FINISH, Q_HIGH, 16'h0003, KIND_PRN_C, 0, 0));
        send_word(make_word(CMD_REMOVE, Q_HIGH, 16'haaaa, KIND_DISK, 0, 0));
        send_word(make_word(CMD_REMOVE, Q_HIGH, 16'h1234, KIND_DISK, 0, 0));
        send_word(make_word(CMD_POP, Q_LOW, 16'h0, KIND_DISK, 0, 0));
        send_word(make_word(3'd5, Q_HIGH, 16'h1, KIND_DISK, 1, 1));
        send_word(make_word(3'd7, Q_NONE, 16'hffff, KIND_BAD, '1, '1));
        wait_drained();
    endtask

    // fill every queue, overflow, then route into a full destination
    task automatic test_full_queues();
        for (int i = 0; i < DEPTH + 1; i++)
        begin
            send_word(make_word(CMD_ENQ, Q_HIGH, 16'(100 + i), KIND_DISK, 0, 0));
            send_word(make_word(CMD_ENQ, Q_LOW, 16'(200 + i), KIND_DISK, 0, 0));
            send_word(make_word(CMD_IO_START, Q_IO, 16'(300 + i), KIND_DISK, 32'(i), 7));
        end
        send_word(make_word(CMD_ENQ, Q_IO, 16'h1, KIND_DISK, 0, 0));
        send_word(make_word(CMD_IO_FINISH, Q_HIGH, 16'd300, KIND_DISK, 0, 0));
        send_word(make_word(CMD_IO_FINISH, Q_HIGH, 16'd315, KIND_PRN_C, 0, 0));
        send_word(make_word(CMD_REMOVE, Q_IO, 16'd315, KIND_DISK, 0, 0));
        send_word(make_word(CMD_REMOVE, Q_HIGH, 16'd108, KIND_DISK, 0, 0));
        for (int i = 0; i < 3 * DEPTH; i++)
            send_word(make_word(CMD_POP, 2'(i % 3), 16'h0, KIND_DISK, 0, 0));
        wait_drained();
    endtask

    task automatic test_random(int n, int idle, int stall);
        idle_pct = idle;
        stall_pct = stall;
        repeat (n) send_word(random_word());
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_receiver = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_receiver = 1'b0;
            end
            repeat (20) send_word(random_word());
        join
        wait_drained();
    endtask

    // receiver side and result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else
            out_stall <= hold_receiver || (stall_pct > 0 && $urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        pqs_out_t exp_word;
        if (rst_n && out_valid && !out_stall)
        begin
            words_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", out_data);
            end
            else
            begin
                exp_word = pending_results.pop_front();
                if (out_data !== exp_word)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_word, out_data);
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("process_queue_set_with_io_routing_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_receiver = 1'b0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_queues();
        test_random(150, 0, 0);
        test_random(150, 73, 0);
        wait_drained();
        test_random(150, 0, 73);
        test_random(150, 17, 17);
        test_backpressure();
        wait_drained();
        if (pending_results.size() > 0)
            mismatches++;
        $display("sent %0d words, checked %0d results across queue fill, routing and idling",
                 words_sent, words_checked);
        if (mismatches == 0)
            $display("process_queue_set_with_io_routing_top regression: pass");
        else
            $display("process_queue_set_with_io_routing_top regression: fail");
        $finish;
    end

endmodule

@@ process_queue_set_with_io_routing_top.f @@
rtl/pqs_pkg.sv
rtl/pqs_datapath.sv
rtl/pqs_ctrl.sv
rtl/process_queue_set_with_io_routing_top.sv
dv/tb_process_queue_set_with_io_routing_top.sv
